FILE: rtl/rlrb_pkg.sv
// Shared types and constants for the run-length region boundary block.
package rlrb_pkg;

  localparam int ROW_W       = 10;
  localparam int COL_W       = 10;
  localparam int CHUNK_IDX_W = 4;
  localparam int WORD_W      = 64;
  localparam int COLOR_W     = 24;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFF_FFFF;

  // Register index taken from paddr[2].
  localparam logic REG_DRAW_COLOR = 1'b0;

  typedef logic [WORD_W-1:0] word_t;

  // One memory entry: one 64-pixel column group of every row bitmap.
  typedef struct packed {
    word_t prev_row;
    word_t cur_row;
    word_t cur_edge;
    word_t next_row;
    word_t next_edge;
  } rlrb_entry_t;

  // Write-back applied to an entry during a sweep.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_ADD,
    WR_SHIFT
  } wr_op_t;

  // Per-word control carried from the sequencer to the word stage.
  typedef struct packed {
    wr_op_t           wr_op;
    logic             emit;
    logic             from_next;
    logic             whole;
    logic             use_above;
    logic             use_below;
    logic             run_end;
    logic [ROW_W-1:0] row;
    logic             span_ok;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
  } rlrb_ctx_t;

endpackage

FILE: rtl/rlrb_mem.sv
// Bitmap memory: one write port, one registered read port, same-address bypass.
module rlrb_mem import rlrb_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rlrb_entry_t   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rlrb_entry_t   wr_data
);

  rlrb_entry_t mem [DEPTH];
  rlrb_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // back-to-back sweeps on a one-entry memory hit the entry being written
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/rlrb_word.sv
// Word stage: boundary chunk and write-back entry for one column group.
module rlrb_word import rlrb_pkg::*; #(
  parameter int AW = 4
) (
  input  rlrb_ctx_t     ctx,
  input  logic [AW-1:0] word_idx,
  input  rlrb_entry_t   rd_entry,
  output word_t         emit_bits,
  output rlrb_entry_t   wr_entry
);

  logic [CHUNK_IDX_W-1:0] idx;
  logic [CHUNK_IDX_W-1:0] left_w;
  logic [CHUNK_IDX_W-1:0] right_w;
  logic                   at_left;
  logic                   at_right;
  logic                   in_range;
  logic [5:0]             lo_off;
  logic [5:0]             hi_off;
  word_t                  fill;
  word_t                  edge_m;
  word_t                  keep;

  assign idx     = CHUNK_IDX_W'(word_idx);
  assign left_w  = ctx.left[COL_W-1:6];
  assign right_w = ctx.right[COL_W-1:6];

  assign at_left  = ctx.span_ok && (idx == left_w);
  assign at_right = ctx.span_ok && (idx == right_w);
  assign in_range = ctx.span_ok && (idx >= left_w) && (idx <= right_w);

  assign lo_off = at_left  ? ctx.left[5:0]  : 6'd0;
  assign hi_off = at_right ? ctx.right[5:0] : 6'd63;

  assign fill = in_range ?
                (({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (6'd63 - hi_off))) : '0;

  assign edge_m = (at_left  ? (word_t'(1'b1) << ctx.left[5:0])  : '0) |
                  (at_right ? (word_t'(1'b1) << ctx.right[5:0]) : '0);

  // pixel stays if it is an endpoint or a neighbor row does not cover it
  assign keep = rd_entry.cur_edge |
                (ctx.use_above ? ~rd_entry.prev_row : '1) |
                (ctx.use_below ? ~rd_entry.next_row : '1);

  always_comb begin
    if (ctx.from_next) begin
      emit_bits = rd_entry.next_row;
    end else if (ctx.whole) begin
      emit_bits = rd_entry.cur_row;
    end else begin
      emit_bits = rd_entry.cur_row & keep;
    end
  end

  always_comb begin
    wr_entry = rd_entry;
    unique case (ctx.wr_op)
      WR_NONE: begin
        wr_entry = rd_entry;
      end
      WR_CLEAR: begin
        wr_entry.prev_row  = '0;
        wr_entry.cur_row   = '0;
        wr_entry.cur_edge  = '0;
        wr_entry.next_row  = fill;
        wr_entry.next_edge = edge_m;
      end
      WR_ADD: begin
        wr_entry.next_row  = rd_entry.next_row | fill;
        wr_entry.next_edge = rd_entry.next_edge | edge_m;
      end
      WR_SHIFT: begin
        wr_entry.prev_row  = rd_entry.cur_row;
        wr_entry.cur_row   = rd_entry.next_row;
        wr_entry.cur_edge  = rd_entry.next_edge;
        wr_entry.next_row  = fill;
        wr_entry.next_edge = edge_m;
      end
    endcase
  end

endmodule

FILE: rtl/rlrb_seq.sv
// Sweep sequencer: takes spans, tracks held rows, issues memory sweeps.
module rlrb_seq import rlrb_pkg::*; #(
  parameter int CHUNKS     = 16,
  parameter int AW         = 4,
  parameter int COLS       = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ROW_W-1:0] in_row,
  input  logic [COL_W-1:0] in_left,
  input  logic [COL_W-1:0] in_right,
  input  logic             in_final,
  input  logic             issue_ok,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output rlrb_ctx_t        ctx
);

  localparam logic [AW-1:0]    LAST_WORD  = AW'(CHUNKS - 1);
  localparam logic [COL_W-1:0] COL_MAX    = COL_W'(COLS - 1);
  localparam logic [12:0]      HEIGHT_LIM = 13'(IMG_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_NEW,
    ST_ADD,
    ST_SHIFT,
    ST_FSHIFT,
    ST_CUR,
    ST_NEXT
  } state_t;

  typedef enum logic [2:0] {
    HELD_NONE,
    HELD_NEXT,
    HELD_TWO,
    HELD_THREE,
    HELD_LAST
  } held_t;

  state_t           state_r,    state_nxt;
  held_t            held_r,     held_nxt;
  logic [AW-1:0]    word_r,     word_nxt;
  logic [ROW_W-1:0] prev_row_r, prev_row_nxt;
  logic [ROW_W-1:0] cur_row_r,  cur_row_nxt;
  logic [ROW_W-1:0] next_row_r, next_row_nxt;
  logic [ROW_W-1:0] row_r,      row_nxt;
  logic [COL_W-1:0] left_r,     left_nxt;
  logic [COL_W-1:0] right_r,    right_nxt;
  logic             span_ok_r,  span_ok_nxt;
  logic             final_r,    final_nxt;

  logic             fire;
  logic             sweep_end;
  logic             two_plus;
  logic [COL_W-1:0] right_clip;
  logic [ROW_W:0]   prev_p1;
  logic [ROW_W:0]   cur_p1;

  assign in_stall  = (state_r != ST_IDLE);
  assign fire      = (state_r != ST_IDLE) && issue_ok;
  assign sweep_end = fire && (word_r == LAST_WORD);
  assign rd_en     = fire;
  assign rd_addr   = word_r;

  assign two_plus   = (held_r == HELD_TWO) || (held_r == HELD_THREE);
  assign right_clip = (in_right > COL_MAX) ? COL_MAX : in_right;
  assign prev_p1    = {1'b0, prev_row_r} + {{ROW_W{1'b0}}, 1'b1};
  assign cur_p1     = {1'b0, cur_row_r} + {{ROW_W{1'b0}}, 1'b1};

  // context of the word being issued, from the state before this sweep
  always_comb begin
    ctx           = '0;
    ctx.wr_op     = WR_NONE;
    ctx.whole     = (held_r != HELD_THREE);
    ctx.use_above = (held_r == HELD_THREE) && (prev_p1 == {1'b0, cur_row_r});
    ctx.use_below = (cur_p1 == {1'b0, next_row_r});
    ctx.row       = cur_row_r;
    ctx.span_ok   = span_ok_r;
    ctx.left      = left_r;
    ctx.right     = right_r;
    unique case (state_r)
      ST_IDLE: begin
        ctx.wr_op = WR_NONE;
      end
      ST_LAST: begin
        ctx.emit    = 1'b1;
        ctx.whole   = 1'b1;
        ctx.run_end = !final_r;
      end
      ST_NEW: begin
        ctx.wr_op = WR_CLEAR;
      end
      ST_ADD: begin
        ctx.wr_op = WR_ADD;
      end
      ST_SHIFT: begin
        ctx.wr_op   = WR_SHIFT;
        ctx.emit    = two_plus;
        ctx.run_end = !final_r;
      end
      ST_FSHIFT: begin
        ctx.wr_op   = WR_SHIFT;
        ctx.span_ok = 1'b0;
        ctx.emit    = 1'b1;
        ctx.run_end = 1'b1;
      end
      ST_CUR: begin
        ctx.emit = 1'b1;
      end
      ST_NEXT: begin
        ctx.emit      = 1'b1;
        ctx.from_next = 1'b1;
        ctx.whole     = 1'b1;
        ctx.row       = next_row_r;
        ctx.run_end   = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    word_nxt     = word_r;
    prev_row_nxt = prev_row_r;
    cur_row_nxt  = cur_row_r;
    next_row_nxt = next_row_r;
    row_nxt      = row_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    span_ok_nxt  = span_ok_r;
    final_nxt    = final_r;

    if (state_r == ST_IDLE) begin
      if (in_valid) begin
        row_nxt     = in_row;
        left_nxt    = in_left;
        right_nxt   = right_clip;
        span_ok_nxt = ({3'b000, in_row} < HEIGHT_LIM) && (in_left <= right_clip);
        final_nxt   = in_final;
        word_nxt    = '0;
        priority if (held_r == HELD_LAST) begin
          state_nxt = ST_LAST;
        end else if (held_r == HELD_NONE) begin
          state_nxt = ST_NEW;
        end else if (in_row == next_row_r) begin
          state_nxt = ST_ADD;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
    end else if (fire) begin
      word_nxt = word_r + AW'(1);
      if (sweep_end) begin
        word_nxt = '0;
        unique case (state_r)
          ST_IDLE: begin
            state_nxt = ST_IDLE;
          end
          ST_LAST: begin
            held_nxt  = HELD_NONE;
            state_nxt = ST_NEW;
          end
          ST_NEW: begin
            held_nxt     = HELD_NEXT;
            next_row_nxt = row_r;
            state_nxt    = final_r ? ST_NEXT : ST_IDLE;
          end
          ST_ADD: begin
            if (!final_r) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = two_plus ? ST_CUR : ST_NEXT;
            end
          end
          ST_SHIFT: begin
            prev_row_nxt = cur_row_r;
            cur_row_nxt  = next_row_r;
            next_row_nxt = row_r;
            held_nxt     = (held_r == HELD_NEXT) ? HELD_TWO : HELD_THREE;
            if (!final_r) begin
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = (held_r == HELD_NEXT) ? ST_CUR : ST_FSHIFT;
            end
          end
          ST_FSHIFT: begin
            prev_row_nxt = cur_row_r;
            cur_row_nxt  = next_row_r;
            held_nxt     = HELD_LAST;
            state_nxt    = ST_IDLE;
          end
          ST_CUR: begin
            state_nxt = ST_NEXT;
          end
          ST_NEXT: begin
            held_nxt  = HELD_NONE;
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_r     <= HELD_NONE;
      word_r     <= '0;
      prev_row_r <= '0;
      cur_row_r  <= '0;
      next_row_r <= '0;
      row_r      <= '0;
      left_r     <= '0;
      right_r    <= '0;
      span_ok_r  <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      word_r     <= word_nxt;
      prev_row_r <= prev_row_nxt;
      cur_row_r  <= cur_row_nxt;
      next_row_r <= next_row_nxt;
      row_r      <= row_nxt;
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      span_ok_r  <= span_ok_nxt;
      final_r    <= final_nxt;
    end
  end

endmodule

FILE: rtl/run_length_region_boundary.sv
// Top level of the run-length region boundary block.
//
// Input channel (in_valid / in_stall): one transaction per span of a region,
// rows nondecreasing, the last span flagged by in_span_final. Output channel
// (out_valid / out_stall): boundary mask of one row, one transaction per
// 64-pixel chunk, all chunks of the row in ascending order; out_run_end marks
// the last chunk caused by a span. draw_color is written over the APB port
// (byte address 0) by the user while the block is idle; the block does not
// enforce this. draw_color is copied into every result.
//
// Memory: the three row bitmaps and the two endpoint bitmaps share one
// memory entry per column group. Every span runs one to three sweeps over
// that memory, one entry per cycle through a read / modify / write-back
// loop unless out_stall pauses it; chunks pass the read register and the
// word stage into the output register. in_stall is high while sweeps run.
// When out_stall holds a result, an emitting word in the word stage waits
// and the sweep pauses; the held result and the memory read data stay put.
// Reset: no region held, draw_color = 0xFFFFFF. The memory is not cleared:
// the first span after reset rewrites every entry in its sweep.
module run_length_region_boundary import rlrb_pkg::*; #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // spans in
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ROW_W-1:0]       in_span_row,
  input  logic [COL_W-1:0]       in_span_left,
  input  logic [COL_W-1:0]       in_span_right,
  input  logic                   in_span_final,
  // boundary chunks out
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ROW_W-1:0]       out_row,
  output logic [CHUNK_IDX_W-1:0] out_chunk_index,
  output logic [WORD_W-1:0]      out_boundary_bits,
  output logic [COLOR_W-1:0]     out_color,
  output logic                   out_run_end
);

  // Columns past 1023 cannot be addressed by a 10-bit span.
  localparam int COLS   = (IMG_WIDTH < 1024) ? IMG_WIDTH : 1024;
  localparam int CHUNKS = (COLS + 63) / 64;
  localparam int AW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(CHUNKS - 1);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [COLOR_W-1:0] draw_color_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DRAW_COLOR);
  // low address bits are ignored, only word-aligned accesses are expected
  assign prdata = (paddr[2] == REG_DRAW_COLOR) ? {{(32 - COLOR_W){1'b0}}, draw_color_r}
                                               : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_color_r <= COLOR_RESET;
    end else if (cfg_wr) begin
      draw_color_r <= pwdata[COLOR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: unless the word stage is held, one word issued per cycle while a sweep runs
  // ---------------------------------------------------------------------
  logic          issue_ok;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  rlrb_ctx_t     issue_ctx;

  rlrb_seq #(
    .CHUNKS     (CHUNKS),
    .AW         (AW),
    .COLS       (COLS),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_row   (in_span_row),
    .in_left  (in_span_left),
    .in_right (in_span_right),
    .in_final (in_span_final),
    .issue_ok (issue_ok),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .ctx      (issue_ctx)
  );

  // ---------------------------------------------------------------------
  // Bitmap memory and word stage (read data arrives in the cycle after issue)
  // ---------------------------------------------------------------------
  logic          s1_valid_r;
  rlrb_ctx_t     s1_ctx_r;
  logic [AW-1:0] s1_word_r;
  logic          s1_go;
  logic          out_free;
  logic          out_load;
  logic          mem_wr_en;
  rlrb_entry_t   rd_entry;
  rlrb_entry_t   wr_entry;
  word_t         emit_bits;

  // an emitting word waits for room in the output register
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_ctx_r.emit || out_free);
  assign issue_ok  = !s1_valid_r || s1_go;
  assign mem_wr_en = s1_go && (s1_ctx_r.wr_op != WR_NONE);
  assign out_load  = s1_go && s1_ctx_r.emit;

  rlrb_mem #(
    .DEPTH (CHUNKS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_word_r),
    .wr_data (wr_entry)
  );

  rlrb_word #(
    .AW (AW)
  ) u_word (
    .ctx       (s1_ctx_r),
    .word_idx  (s1_word_r),
    .rd_entry  (rd_entry),
    .emit_bits (emit_bits),
    .wr_entry  (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (issue_ok) begin
      s1_valid_r <= rd_en;
    end
    if (rd_en) begin
      s1_ctx_r  <= issue_ctx;
      s1_word_r <= rd_addr;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: parts the word stage from the receiver
  // ---------------------------------------------------------------------
  logic                   out_valid_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [CHUNK_IDX_W-1:0] out_chunk_r;
  word_t                  out_bits_r;
  logic [COLOR_W-1:0]     out_color_r;
  logic                   out_run_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_row_r     <= s1_ctx_r.row;
      out_chunk_r   <= CHUNK_IDX_W'(s1_word_r);
      out_bits_r    <= emit_bits;
      out_color_r   <= draw_color_r;
      out_run_end_r <= s1_ctx_r.run_end && (s1_word_r == LAST_WORD);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_chunk_index   = out_chunk_r;
  assign out_boundary_bits = out_bits_r;
  assign out_color         = out_color_r;
  assign out_run_end       = out_run_end_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a stalled word stage must keep its read data: no new read may go out
  a_no_read_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |-> !rd_en)
    else $error("memory read issued while the word stage is held");

  // every issued read lands in the word stage
  a_issue_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_valid_r)
    else $error("issued word lost before the word stage");

  // a span's results always end on the last chunk of a row
  a_run_end_last_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_run_end_r) |-> (out_chunk_r == CHUNK_IDX_W'(CHUNKS - 1)))
    else $error("run end flagged on a chunk other than the last");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the run-length region boundary block.
`timescale 1ns / 100ps

module tb_top;
  import rlrb_pkg::*;

  localparam int NCHUNK = 16;                   // 1024 columns / 64
  localparam logic [2:0] ADDR_DRAW_COLOR = {REG_DRAW_COLOR, 2'b00};
  localparam int SETTLE_CYCLES = 100;           // > worst sweep time of one span

  // One boundary mask chunk as it should leave the block.
  typedef struct {
    logic [ROW_W-1:0]       row;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic [WORD_W-1:0]      bits;
    logic [COLOR_W-1:0]     color;
    logic                   last;
  } mask_chunk_t;

  // Boundary predictor plus the queue of chunks still owed by the block.
  class BoundaryScoreboard;
    word_t upper_map [NCHUNK];      // row above the judged row
    word_t mid_map   [NCHUNK];      // row being judged
    word_t mid_ends  [NCHUNK];
    word_t fresh_map [NCHUNK];      // row still being gathered
    word_t fresh_ends[NCHUNK];
    logic [ROW_W-1:0]   row_upper, row_mid, row_fresh;
    int                 held;       // 0 idle .. 3 all rows, 4 last row parked
    logic [COLOR_W-1:0] color;
    mask_chunk_t        owed[$];
    int                 errors, chunks_seen, chunks_marked;

    function void wipe();
      foreach (upper_map[w]) begin
        upper_map[w] = '0;
        mid_map[w] = '0;
        mid_ends[w] = '0;
        fresh_map[w] = '0;
        fresh_ends[w] = '0;
      end
    endfunction

    function void reset_state();
      wipe();
      row_upper = '0;
      row_mid = '0;
      row_fresh = '0;
      held = 0;
      color = COLOR_RESET;
    endfunction

    function void set_color(logic [COLOR_W-1:0] c);
      color = c;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Rows and columns are 10 bits, so every row lies inside the 1024-row
    // image and the right end never needs clipping at 1024 columns.
    function void paint(logic [COL_W-1:0] lft, logic [COL_W-1:0] rgt);
      int l, r, lo, hi, n;
      word_t m;
      l = lft;
      r = rgt;
      if (l > r) return;
      for (int w = l / 64; w <= r / 64; w++) begin
        lo = (l > w * 64) ? l : w * 64;
        hi = (r < w * 64 + 63) ? r : w * 64 + 63;
        n = hi - lo + 1;
        m = (n >= 64) ? {WORD_W{1'b1}} : ((64'd1 << n) - 64'd1);
        fresh_map[w] |= m << (lo % 64);
      end
      fresh_ends[l / 64] |= 64'd1 << (l % 64);
      fresh_ends[r / 64] |= 64'd1 << (r % 64);
    endfunction

    function void queue_row(logic [ROW_W-1:0] rnum, bit from_fresh, bit whole,
                            bit use_above, bit use_below);
      word_t b, m;
      mask_chunk_t c;
      for (int w = 0; w < NCHUNK; w++) begin
        b = from_fresh ? fresh_map[w] : mid_map[w];
        if (!whole) begin
          m = from_fresh ? fresh_ends[w] : mid_ends[w];
          m |= use_above ? ~upper_map[w] : {WORD_W{1'b1}};
          m |= use_below ? ~fresh_map[w] : {WORD_W{1'b1}};
          b &= m;
        end
        c.row = rnum;
        c.chunk = w;
        c.bits = b;
        c.color = color;
        c.last = 1'b0;
        owed.push_back(c);
      end
    endfunction

    // Judged row against the rows above (if held) and below, where adjacent.
    function void queue_mid();
      bit first, above_ok, below_ok;
      first = held < 3;
      above_ok = !first && ({1'b0, row_upper} + 11'd1 == {1'b0, row_mid});
      below_ok = ({1'b0, row_mid} + 11'd1 == {1'b0, row_fresh});
      queue_row(row_mid, 1'b0, first, above_ok, below_ok);
    endfunction

    function void shift_rows();
      upper_map = mid_map;
      mid_map = fresh_map;
      mid_ends = fresh_ends;
      foreach (fresh_map[w]) begin
        fresh_map[w] = '0;
        fresh_ends[w] = '0;
      end
      row_upper = row_mid;
      row_mid = row_fresh;
    endfunction

    // Called once per accepted span transaction.
    function void note_span(logic [ROW_W-1:0] r, logic [COL_W-1:0] lft,
                            logic [COL_W-1:0] rgt, logic fin);
      int k;
      k = 0;
      if (held >= 4) begin
        // parked last row of the previous region goes out first
        queue_row(row_mid, 1'b0, 1'b1, 1'b0, 1'b0);
        k += NCHUNK;
        wipe();
        held = 0;
      end
      if (held == 0) begin
        wipe();
        row_fresh = r;
        paint(lft, rgt);
        held = 1;
      end else if (r == row_fresh) begin
        paint(lft, rgt);
      end else begin
        if (held >= 2) begin
          queue_mid();
          k += NCHUNK;
        end
        shift_rows();
        row_fresh = r;
        paint(lft, rgt);
        if (held < 3) held++;
      end
      if (fin) begin
        if (held >= 2 && k > 0) begin
          queue_mid();
          k += NCHUNK;
          shift_rows();
          held = 4;
        end else begin
          if (held >= 2) begin
            queue_mid();
            k += NCHUNK;
          end
          queue_row(row_fresh, 1'b1, 1'b1, 1'b0, 1'b0);
          k += NCHUNK;
          wipe();
          held = 0;
        end
      end
      if (k > 0) owed[owed.size() - 1].last = 1'b1;
    endfunction

    function void check(logic [ROW_W-1:0] r, logic [CHUNK_IDX_W-1:0] ci, word_t b,
                        logic [COLOR_W-1:0] col, logic last);
      mask_chunk_t e;
      chunks_seen++;
      if (b != '0) chunks_marked++;
      if (owed.size() == 0) begin
        $error("unexpected chunk: row %0d chunk %0d bits %h", r, ci, b);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (r !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, r);
        errors++;
      end
      if (ci !== e.chunk) begin
        $error("out_chunk_index: expected %0d, got %0d", e.chunk, ci);
        errors++;
      end
      if (b !== e.bits) begin
        $error("out_boundary_bits: expected %h, got %h", e.bits, b);
        errors++;
      end
      if (col !== e.color) begin
        $error("out_color: expected %h, got %h", e.color, col);
        errors++;
      end
      if (last !== e.last) begin
        $error("out_run_end: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ROW_W-1:0]       in_span_row = '0;
  logic [COL_W-1:0]       in_span_left = '0;
  logic [COL_W-1:0]       in_span_right = '0;
  logic                   in_span_final = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ROW_W-1:0]       out_row;
  logic [CHUNK_IDX_W-1:0] out_chunk_index;
  logic [WORD_W-1:0]      out_boundary_bits;
  logic [COLOR_W-1:0]     out_color;
  logic                   out_run_end;

  BoundaryScoreboard sb = new();
  bit calm = 1'b0;          // when set, neither side idles or stalls
  int stall_left = 0;
  int spans_sent = 0;
  int regions_sent = 0;
  int colors_used = 1;

  run_length_region_boundary DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_span_row      (in_span_row),
    .in_span_left     (in_span_left),
    .in_span_right    (in_span_right),
    .in_span_final    (in_span_final),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_chunk_index  (out_chunk_index),
    .out_boundary_bits(out_boundary_bits),
    .out_color        (out_color),
    .out_run_end      (out_run_end)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: check every accepted transaction, then draw a random stall.
  // Idle stalls also start now and then so a stall can already be up
  // when the first chunk of a row shows up.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check(out_row, out_chunk_index, out_boundary_bits, out_color, out_run_end);
        stall_left = calm ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("[run_length_region_boundary] ERROR");
    $finish;
  end

  // ----------------------------------------------------------------- tasks
  // One span transaction; the predictor sees it at the accepting edge.
  // Leaves in_valid high so back-to-back spans can follow each other directly.
  task automatic send_span(logic [ROW_W-1:0] r, logic [COL_W-1:0] lft,
                           logic [COL_W-1:0] rgt, logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_span_row <= r;
    in_span_left <= lft;
    in_span_right <= rgt;
    in_span_final <= fin;
    do @(posedge clk); while (in_stall);
    sb.note_span(r, lft, rgt, fin);
    spans_sent++;
    if (fin) regions_sent++;
  endtask

  // Hold off until every owed chunk has arrived, then let a span that owes
  // nothing finish its sweeps.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; pready is always high.
  task automatic write_color(logic [COLOR_W-1:0] c);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_DRAW_COLOR;
    pwdata <= {8'h00, c};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_color(c);
    colors_used++;
  endtask

  task automatic pick_cols(output logic [COL_W-1:0] lft, output logic [COL_W-1:0] rgt);
    int r;
    case ($urandom_range(0, 7))
      0: begin            // anything, empty spans included
        lft = $urandom_range(0, 1023);
        rgt = $urandom_range(0, 1023);
      end
      1: begin            // near full width
        lft = $urandom_range(0, 63);
        rgt = $urandom_range(960, 1023);
      end
      default: begin
        lft = $urandom_range(0, 1023);
        r = lft + $urandom_range(0, 150);
        rgt = (r > 1023) ? 10'd1023 : r[COL_W-1:0];
      end
    endcase
  endtask

  // A well-formed region: rows mostly ascending by one, sometimes a gap,
  // sometimes a step back; 10-bit rows wrap past 1023 on their own.
  task automatic send_region();
    int nrows, nspans, sel;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] lft, rgt;
    nrows = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
    r = $urandom_range(0, 1023);
    for (int i = 0; i < nrows; i++) begin
      nspans = $urandom_range(1, 3);
      for (int j = 0; j < nspans; j++) begin
        pick_cols(lft, rgt);
        send_span(r, lft, rgt, (i == nrows - 1) && (j == nspans - 1));
      end
      sel = $urandom_range(0, 9);
      if (sel < 7) r = r + 1;
      else if (sel < 9) r = r + $urandom_range(2, 4);
      else r = r - 1;
    end
  endtask

  // Random fields with no structure, final flag set now and then.
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_span($urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 3) == 0);
  endtask

  // ------------------------------------------------------------- main flow
  initial begin
    int phase_start;
    logic [COLOR_W-1:0] phase_color [4];
    sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, draw_color at its reset value.
    // single-row region over the full width: every pixel is boundary
    send_span(10'd5, 10'd0, 10'd1023, 1'b1);
    // several spans per row, an isolated pixel, a row gap and an empty final
    // span on a new row, which parks the last row
    send_span(10'd10, 10'd3, 10'd70, 1'b0);
    send_span(10'd10, 10'd100, 10'd100, 1'b0);
    send_span(10'd11, 10'd0, 10'd200, 1'b0);
    send_span(10'd12, 10'd60, 10'd130, 1'b0);
    send_span(10'd14, 10'd0, 10'd1023, 1'b0);
    send_span(10'd15, 10'd900, 10'd10, 1'b1);
    // parked row goes out first; then 1023 -> 0 must not count as adjacent
    send_span(10'd1023, 10'd500, 10'd600, 1'b0);
    send_span(10'd0, 10'd500, 10'd600, 1'b1);
    // row number stepping back opens a new row too
    send_span(10'd300, 10'd0, 10'd63, 1'b0);
    send_span(10'd299, 10'd64, 10'd127, 1'b0);
    send_span(10'd300, 10'd63, 10'd64, 1'b1);
    // empty single-span region: a whole row of zero chunks
    send_span(10'd7, 10'd1023, 10'd0, 1'b1);
    drain();

    write_color(24'h000000);
    // two-row region: both rows emitted whole by the final span
    send_span(10'd20, 10'd10, 10'd20, 1'b0);
    send_span(10'd21, 10'd15, 10'd25, 1'b1);
    // final span on a row already open
    send_span(10'd40, 10'd0, 10'd10, 1'b0);
    send_span(10'd41, 10'd0, 10'd10, 1'b0);
    send_span(10'd42, 10'd0, 10'd10, 1'b0);
    send_span(10'd42, 10'd20, 10'd30, 1'b1);
    // column extremes on chunk borders
    send_span(10'd600, 10'd63, 10'd64, 1'b0);
    send_span(10'd601, 10'd1023, 10'd1023, 1'b0);
    send_span(10'd602, 10'd0, 10'd0, 1'b1);
    drain();

    // Random part: four phases of about 43 spans, one color each; the
    // third phase runs with no idling on either side.
    phase_color[0] = 24'hFFFFFF;
    phase_color[1] = $urandom_range(0, 24'hFFFFFF);
    phase_color[2] = 24'hA5A55A;
    phase_color[3] = 24'h5A5AA5;
    for (int p = 0; p < 4; p++) begin
      write_color(phase_color[p]);
      calm = (p == 2);
      phase_start = spans_sent;
      while (spans_sent - phase_start < 43) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else send_region();
        // sender holds back until the block has caught up
        if ($urandom_range(0, 5) == 0) drain();
      end
      drain();
    end
    calm = 1'b0;

    $display("covered %0d spans in %0d closed regions with %0d colors,",
             spans_sent, regions_sent, colors_used);
    $display("checked %0d mask chunks, %0d with boundary pixels",
             sb.chunks_seen, sb.chunks_marked);
    if (sb.errors == 0) begin
      $display("[run_length_region_boundary] OK");
    end else begin
      $display("[run_length_region_boundary] ERROR");
    end
    $finish;
  end

endmodule
